// ----- rtl/core/nbcd_pkg.sv -----
// Package with the shared constants, codes and types of the nibble blitter.
package nbcd_pkg;

  localparam int unsigned ClutEntries = 4096;
  localparam int unsigned ClutW       = 8;
  localparam int unsigned ColW        = 9;
  localparam int unsigned PixXW       = 10;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 9;

  localparam logic [ClutW-1:0] ClutClear = 8'hff;
  localparam logic [PixXW-1:0] XMirror   = 10'h3ff;
  localparam logic [ColW-1:0]  YMirror   = 9'h1ff;

  typedef enum logic [1:0] {
    OpStart = 2'd0,
    OpByte  = 2'd1,
    OpClut  = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegDestX  = 3'd0,
    RegDestY  = 3'd1,
    RegSizeX  = 3'd2,
    RegSizeY  = 3'd3,
    RegFlags  = 3'd4,
    RegBank   = 3'd5,
    RegLayer  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [PixXW-1:0] x_first;
    logic [PixXW-1:0] x_second;
    logic [ColW-1:0]  y;
    logic             tag;
    logic             transp;
    logic             last;
  } pix_stage_t;

endpackage

// ----- rtl/core/nbcd_ram.sv -----
// Generic RAM with one write port and two registered read ports.
module nbcd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- rtl/core/nibble_blitter_clut_draw_top.sv -----
// Top level of the nibble blitter: rectangle walk, lookup and pixel output.
//
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+-------------------------------------
// request  | in        | in_valid_i / in_ready_o  | op, pixel_byte, clut_index, clut_value
// pixel    | out       | out_valid_o / out_ready_i| positions, colors, write flags, last
// config   | in        | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// One request is taken per cycle while in_ready_o is high. A graphics byte reads the lookup
// RAM and loads the lookup stage register when it is taken; the stage then loads the output
// register once the output register is empty or being read.
// The lookup RAM has no reset, so every entry must be written before it is used.
// A stalled output fills the lookup stage, and then the request side stalls too.
// CLUT_ENTRIES is expected to be a power of two.
module nibble_blitter_clut_draw_top import nbcd_pkg::*; #(
  parameter int unsigned CLUT_ENTRIES = ClutEntries
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  input  logic [7:0]          pixel_byte_i,
  input  logic [11:0]         clut_index_i,
  input  logic [7:0]          clut_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PixXW-1:0]    pixel_x_first_o,
  output logic [PixXW-1:0]    pixel_x_second_o,
  output logic [ColW-1:0]     pixel_y_o,
  output logic [ColW-1:0]     color_first_o,
  output logic [ColW-1:0]     color_second_o,
  output logic                write_first_o,
  output logic                write_second_o,
  output logic                rect_last_o
);

  localparam int unsigned AddrW = $clog2(CLUT_ENTRIES);

  logic [8:0] dest_x_q, dest_y_q;
  logic [7:0] size_x_q, size_y_q;
  logic [4:0] flags_q;
  logic [7:0] bank_q;
  logic       layer_q;

  logic [4:0] lat_flags_q;
  logic [7:0] lat_bank_q;
  logic       lat_layer_q;
  logic [7:0] lat_sx_q;
  logic [8:0] lat_x0_q;
  logic [8:0] cur_x_q, cur_x_d;
  logic [8:0] cur_y_q, cur_y_d;
  logic [7:0] cols_q, cols_d;
  logic [7:0] rows_q, rows_d;
  logic       busy_q, busy_d;

  logic       in_acc;
  logic       byte_acc;
  logic       clut_we;
  op_e        op;

  pix_stage_t stage_d, stage_q;
  logic       stage_valid_q;
  logic       stage_adv;

  logic [3:0]       nib_first, nib_second;
  logic [11:0]      raddr_a_full, raddr_b_full;
  logic [ClutW-1:0] rd_a, rd_b;
  logic [8:0]       start_x0, start_y;

  logic [PixXW-1:0] out_x1_q, out_x2_q;
  logic [ColW-1:0]  out_y_q, out_c1_q, out_c2_q;
  logic             out_w1_q, out_w2_q, out_last_q, out_valid_q;

  assign op         = op_e'(op_i);
  assign in_ready_o = !stage_valid_q || !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign byte_acc   = in_acc && (op == OpByte) && busy_q;
  assign clut_we    = in_acc && (op == OpClut);
  assign stage_adv  = stage_valid_q && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_x_q <= '0;
      dest_y_q <= '0;
      size_x_q <= '0;
      size_y_q <= '0;
      flags_q  <= '0;
      bank_q   <= '0;
      layer_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegDestX: dest_x_q <= cfg_data_i;
        RegDestY: dest_y_q <= cfg_data_i;
        RegSizeX: size_x_q <= cfg_data_i[7:0];
        RegSizeY: size_y_q <= cfg_data_i[7:0];
        RegFlags: flags_q  <= cfg_data_i[4:0];
        RegBank:  bank_q   <= cfg_data_i[7:0];
        RegLayer: layer_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign start_x0 = flags_q[0] ? dest_x_q : dest_x_q + {1'b0, size_x_q};
  assign start_y  = flags_q[1] ? dest_y_q : dest_y_q + {1'b0, size_y_q};

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    cols_d  = cols_q;
    rows_d  = rows_q;
    busy_d  = busy_q;
    if (in_acc && (op == OpStart)) begin
      cur_x_d = start_x0;
      cur_y_d = start_y;
      cols_d  = size_x_q;
      rows_d  = size_y_q;
      busy_d  = 1'b1;
    end else if (byte_acc) begin
      if (cols_q != '0) begin
        cols_d  = cols_q - 8'd1;
        cur_x_d = lat_flags_q[0] ? cur_x_q + 9'd1 : cur_x_q - 9'd1;
      end else if (rows_q != '0) begin
        rows_d  = rows_q - 8'd1;
        cols_d  = lat_sx_q;
        cur_x_d = lat_x0_q;
        cur_y_d = lat_flags_q[1] ? cur_y_q + 9'd1 : cur_y_q - 9'd1;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_flags_q <= '0;
      lat_bank_q  <= '0;
      lat_layer_q <= 1'b0;
      lat_sx_q    <= '0;
      lat_x0_q    <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      cols_q      <= '0;
      rows_q      <= '0;
      busy_q      <= 1'b0;
    end else begin
      if (in_acc && (op == OpStart)) begin
        lat_flags_q <= flags_q;
        lat_bank_q  <= bank_q;
        lat_layer_q <= layer_q;
        lat_sx_q    <= size_x_q;
        lat_x0_q    <= start_x0;
      end
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      cols_q  <= cols_d;
      rows_q  <= rows_d;
      busy_q  <= busy_d;
    end
  end

  assign nib_first    = lat_flags_q[0] ? pixel_byte_i[3:0] : pixel_byte_i[7:4];
  assign nib_second   = lat_flags_q[0] ? pixel_byte_i[7:4] : pixel_byte_i[3:0];
  assign raddr_a_full = {lat_bank_q, nib_first};
  assign raddr_b_full = {lat_bank_q, nib_second};

  nbcd_ram #(
    .Width (ClutW),
    .Depth (CLUT_ENTRIES)
  ) u_clut_ram (
    .clk_i     (clk_i),
    .we_i      (clut_we),
    .waddr_i   (clut_index_i[AddrW-1:0]),
    .wdata_i   (clut_value_i),
    .re_i      (byte_acc),
    .raddr_a_i (raddr_a_full[AddrW-1:0]),
    .raddr_b_i (raddr_b_full[AddrW-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_comb begin
    stage_d.x_first  = {cur_x_q, 1'b0};
    stage_d.x_second = {cur_x_q, 1'b1};
    stage_d.y        = cur_y_q;
    if (!lat_flags_q[2]) begin
      stage_d.x_first  = stage_d.x_first ^ XMirror;
      stage_d.x_second = stage_d.x_second ^ XMirror;
      stage_d.y        = stage_d.y ^ YMirror;
    end
    stage_d.tag    = lat_flags_q[4] && lat_layer_q;
    stage_d.transp = lat_flags_q[3];
    stage_d.last   = (cols_q == '0) && (rows_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (byte_acc) begin
      stage_valid_q <= 1'b1;
    end else if (stage_adv) begin
      stage_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_acc) begin
      stage_q <= stage_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_adv) begin
      out_x1_q   <= stage_q.x_first;
      out_x2_q   <= stage_q.x_second;
      out_y_q    <= stage_q.y;
      out_c1_q   <= {stage_q.tag, rd_a};
      out_c2_q   <= {stage_q.tag, rd_b};
      out_w1_q   <= !(stage_q.transp && (rd_a == ClutClear));
      out_w2_q   <= !(stage_q.transp && (rd_b == ClutClear));
      out_last_q <= stage_q.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pixel_x_first_o  = out_x1_q;
  assign pixel_x_second_o = out_x2_q;
  assign pixel_y_o        = out_y_q;
  assign color_first_o    = out_c1_q;
  assign color_second_o   = out_c2_q;
  assign write_first_o    = out_w1_q;
  assign write_second_o   = out_w2_q;
  assign rect_last_o      = out_last_q;

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench of the nibble blitter that predicts every pixel write of each rectangle.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nbcd_pkg::*;

  localparam logic [1:0]         OpUnused  = 2'd3;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  localparam int FlagXAsc     = 0;
  localparam int FlagYAsc     = 1;
  localparam int FlagUnmirror = 2;
  localparam int FlagTransp   = 3;
  localparam int FlagTag      = 4;

  localparam int RandomRequests = 1100;
  localparam int RxHoldCycles   = 300;
  localparam int SettleCycles   = 4;
  localparam int WatchdogLimit  = 3000;
  localparam int MaxReports     = 50;

  typedef struct packed {
    logic [PixXW-1:0] x_first;
    logic [PixXW-1:0] x_second;
    logic [ColW-1:0]  y;
    logic [ColW-1:0]  color_first;
    logic [ColW-1:0]  color_second;
    logic             write_first;
    logic             write_second;
    logic             last;
  } pixel_t;

  class rect_painter;
    bit [8:0] dest_x, dest_y;
    bit [7:0] size_x, size_y, bank;
    bit [4:0] flags;
    bit       layer;

    bit [7:0] clut [ClutEntries];
    bit       clut_written [ClutEntries];

    bit       active;
    bit [8:0] lat_x0, cur_x, cur_y;
    bit [7:0] lat_sx, lat_bank, cols_left, rows_left;
    bit [4:0] lat_flags;
    bit       lat_layer;

    pixel_t pixels_due[$];
    int     mismatches;

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegDestX: dest_x = data;
        RegDestY: dest_y = data;
        RegSizeX: size_x = data[7:0];
        RegSizeY: size_y = data[7:0];
        RegFlags: flags = data[4:0];
        RegBank:  bank = data[7:0];
        RegLayer: layer = data[0];
        default: ;
      endcase
    endfunction

    function bit [ColW-1:0] translate(bit [3:0] nib);
      bit [ColW-1:0] c;
      c = {1'b0, clut[{lat_bank, nib}]};
      if (lat_flags[FlagTag]) c[ColW-1] = lat_layer;
      return c;
    endfunction

    // Returns 1 when the request changes the state or produces a pixel write.
    function bit accept_request(logic [1:0] op, logic [7:0] pix, logic [11:0] idx,
                                logic [7:0] val);
      pixel_t   p;
      bit [3:0] nib_a, nib_b;
      case (op)
        OpStart: begin
          lat_flags = flags;
          lat_bank  = bank;
          lat_layer = layer;
          lat_sx    = size_x;
          lat_x0    = flags[FlagXAsc] ? dest_x : dest_x + {1'b0, size_x};
          cur_x     = lat_x0;
          cur_y     = flags[FlagYAsc] ? dest_y : dest_y + {1'b0, size_y};
          cols_left = size_x;
          rows_left = size_y;
          active    = 1'b1;
          return 1'b1;
        end
        OpClut: begin
          clut[idx] = val;
          clut_written[idx] = 1'b1;
          return 1'b1;
        end
        OpByte: if (active) begin
          {nib_b, nib_a} = pix;
          if (!lat_flags[FlagXAsc]) {nib_a, nib_b} = pix;
          p.color_first  = translate(nib_a);
          p.color_second = translate(nib_b);
          p.write_first  = !(lat_flags[FlagTransp] && p.color_first[7:0] == ClutClear);
          p.write_second = !(lat_flags[FlagTransp] && p.color_second[7:0] == ClutClear);
          p.x_first      = {cur_x, 1'b0};
          p.x_second     = {cur_x, 1'b1};
          p.y            = cur_y;
          if (!lat_flags[FlagUnmirror]) begin
            p.x_first  ^= XMirror;
            p.x_second ^= XMirror;
            p.y        ^= YMirror;
          end
          p.last = 1'b0;
          if (cols_left != 0) begin
            cols_left--;
            cur_x = lat_flags[FlagXAsc] ? cur_x + 9'd1 : cur_x - 9'd1;
          end else if (rows_left != 0) begin
            rows_left--;
            cols_left = lat_sx;
            cur_x     = lat_x0;
            cur_y     = lat_flags[FlagYAsc] ? cur_y + 9'd1 : cur_y - 9'd1;
          end else begin
            p.last = 1'b1;
            active = 1'b0;
          end
          pixels_due.push_back(p);
          return 1'b1;
        end
        default: ;
      endcase
      return 1'b0;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MaxReports) $display("%0t mismatch: %s", $time, msg);
    endtask

    task diff_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s is %0h, want %0h", name, got, want));
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        report($sformatf("pixel write at x %0d y %0d with none pending", got.x_first, got.y));
        return;
      end
      want = pixels_due.pop_front();
      diff_field("pixel_x_first", 16'(got.x_first), 16'(want.x_first));
      diff_field("pixel_x_second", 16'(got.x_second), 16'(want.x_second));
      diff_field("pixel_y", 16'(got.y), 16'(want.y));
      diff_field("color_first", 16'(got.color_first), 16'(want.color_first));
      diff_field("color_second", 16'(got.color_second), 16'(want.color_second));
      diff_field("write_first", 16'(got.write_first), 16'(want.write_first));
      diff_field("write_second", 16'(got.write_second), 16'(want.write_second));
      diff_field("rect_last", 16'(got.last), 16'(want.last));
    endtask
  endclass

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [1:0]          op_i         = '0;
  logic [7:0]          pixel_byte_i = '0;
  logic [11:0]         clut_index_i = '0;
  logic [7:0]          clut_value_i = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [PixXW-1:0]    pixel_x_first_o;
  logic [PixXW-1:0]    pixel_x_second_o;
  logic [ColW-1:0]     pixel_y_o;
  logic [ColW-1:0]     color_first_o;
  logic [ColW-1:0]     color_second_o;
  logic                write_first_o;
  logic                write_second_o;
  logic                rect_last_o;

  rect_painter tracker = new;
  int          useful_requests;
  int          rx_hold_count;
  int          idle_cycles;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  logic [7:0]  used_banks[$];

  nibble_blitter_clut_draw_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .pixel_byte_i     (pixel_byte_i),
    .clut_index_i     (clut_index_i),
    .clut_value_i     (clut_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pixel_x_first_o  (pixel_x_first_o),
    .pixel_x_second_o (pixel_x_second_o),
    .pixel_y_o        (pixel_y_o),
    .color_first_o    (color_first_o),
    .color_second_o   (color_second_o),
    .write_first_o    (write_first_o),
    .write_second_o   (write_second_o),
    .rect_last_o      (rect_last_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int     holds_seen;
    int     hold_left;
    pixel_t got;
    holds_seen = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = {pixel_x_first_o, pixel_x_second_o, pixel_y_o, color_first_o, color_second_o,
               write_first_o, write_second_o, rect_last_o};
        tracker.check_pixel(got);
      end
      if (holds_seen != rx_hold_count) begin
        holds_seen = rx_hold_count;
        hold_left  = RxHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(rx_idle_en && $urandom_range(99) < 6);
      end
    end
  end

  task automatic send_request(logic [1:0] op, logic [7:0] pix, logic [11:0] idx,
                              logic [7:0] val);
    while (tx_idle_en && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    pixel_byte_i <= pix;
    clut_index_i <= idx;
    clut_value_i <= val;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    if (tracker.accept_request(op, pix, idx, val)) useful_requests++;
  endtask

  task automatic set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pixels_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_color();
    return ($urandom_range(3) == 0) ? ClutClear : 8'($urandom_range(255));
  endfunction

  function automatic logic [8:0] pick_coord();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 9'h1ff : 9'h000;
    return 9'($urandom_range(511));
  endfunction

  task automatic fill_bank(logic [7:0] b);
    for (int e = 0; e < 16; e++) begin
      if (!tracker.clut_written[{b, 4'(e)}])
        send_request(OpClut, 8'($urandom), {b, 4'(e)}, pick_color());
    end
  endtask

  task automatic paint_random_rect(int phase);
    logic [8:0] dx, dy;
    logic [7:0] sx, sy, b;
    logic [4:0] fl;
    int         n;
    int         mode;
    settle();
    mode = $urandom_range(15);
    dx   = pick_coord();
    dy   = pick_coord();
    fl   = 5'($urandom_range(31));
    if (phase == 0) begin
      sx = 8'hff;
      sy = 8'd1;
      n  = 257;
    end else if (mode == 0) begin
      sx = 8'hff;
      sy = 8'($urandom_range(255));
      n  = $urandom_range(5, 30);
    end else if (mode == 1) begin
      sx = 8'($urandom_range(3));
      sy = 8'hff;
      n  = $urandom_range(5, 30);
    end else begin
      sx = 8'($urandom_range(4));
      sy = 8'($urandom_range(4));
      n  = (sx + 1) * (sy + 1);
      if ($urandom_range(5) == 0) n = $urandom_range(n);
    end
    if (used_banks.size() != 0 && $urandom_range(3) != 0) begin
      b = used_banks[$urandom_range(used_banks.size() - 1)];
    end else begin
      b = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hff : 8'h00) : 8'($urandom_range(255));
      used_banks.push_back(b);
    end
    set_reg(RegDestX, dx);
    set_reg(RegDestY, dy);
    set_reg(RegSizeX, {1'($urandom), sx});
    set_reg(RegSizeY, {1'($urandom), sy});
    set_reg(RegFlags, {4'($urandom), fl});
    set_reg(RegBank, {1'($urandom), b});
    set_reg(RegLayer, 9'($urandom));
    if ($urandom_range(3) == 0) set_reg(RegUnused, 9'($urandom));
    fill_bank(b);
    send_request(OpStart, 8'($urandom), 12'($urandom), 8'($urandom));
    if (phase == 0 || phase == 20) rx_hold_count++;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) begin
        if ($urandom_range(1)) send_request(OpClut, 8'($urandom), 12'($urandom), pick_color());
        else send_request(OpUnused, 8'($urandom), 12'($urandom), 8'($urandom));
      end
      send_request(OpByte, 8'($urandom), 12'($urandom), 8'($urandom));
    end
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) send_request(OpByte, 8'($urandom), 12'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Bytes before any start are dropped, and so is the unused opcode.
    send_request(OpClut, 8'h00, 12'h000, 8'h00);
    send_request(OpByte, 8'h00, 12'h000, 8'h00);
    send_request(OpUnused, 8'hff, 12'hfff, 8'hff);
    send_request(OpClut, 8'h00, 12'hfff, 8'hff);
    send_request(OpClut, 8'h00, 12'hff0, 8'h5a);
    settle();

    // Ascending, unmirrored, transparent and tagged, wrapping at the far corner.
    set_reg(RegDestX, 9'h1ff);
    set_reg(RegDestY, 9'h1ff);
    set_reg(RegSizeX, 9'h001);
    set_reg(RegSizeY, 9'h001);
    set_reg(RegFlags, 9'h01f);
    set_reg(RegBank, 9'h0ff);
    set_reg(RegLayer, 9'h1ff);
    set_reg(RegUnused, 9'h1ff);
    send_request(OpStart, 8'h00, 12'h000, 8'h00);
    send_request(OpByte, 8'hf0, 12'h000, 8'h00);
    send_request(OpByte, 8'h0f, 12'h000, 8'h00);
    send_request(OpByte, 8'hff, 12'h000, 8'h00);
    send_request(OpByte, 8'h00, 12'h000, 8'h00);
    send_request(OpByte, 8'h0f, 12'h000, 8'h00);
    settle();

    // Descending and mirrored; new settings written mid-rectangle must wait for a start.
    set_reg(RegFlags, 9'h000);
    set_reg(RegDestX, 9'h000);
    set_reg(RegDestY, 9'h000);
    set_reg(RegSizeX, 9'h000);
    set_reg(RegSizeY, 9'h002);
    send_request(OpStart, 8'h00, 12'h000, 8'h00);
    send_request(OpByte, 8'hf0, 12'h000, 8'h00);
    send_request(OpByte, 8'h0f, 12'h000, 8'h00);
    settle();
    set_reg(RegFlags, 9'h01f);
    set_reg(RegDestX, 9'h064);
    send_request(OpByte, 8'h00, 12'h000, 8'h00);
    settle();

    // A second start abandons the running rectangle; a lookup write lands between bytes.
    set_reg(RegSizeX, 9'h003);
    set_reg(RegSizeY, 9'h000);
    set_reg(RegFlags, 9'h014);
    send_request(OpStart, 8'h00, 12'h000, 8'h00);
    send_request(OpByte, 8'hff, 12'h000, 8'h00);
    send_request(OpStart, 8'h00, 12'h000, 8'h00);
    send_request(OpByte, 8'h0f, 12'h000, 8'h00);
    send_request(OpByte, 8'hf0, 12'h000, 8'h00);
    send_request(OpClut, 8'h00, 12'hfff, 8'h00);
    send_request(OpByte, 8'hff, 12'h000, 8'h00);

    useful_requests = 0;
    for (int phase = 0; useful_requests < RandomRequests; phase++) begin
      tx_idle_en = !(phase >= 8 && phase < 20);
      rx_idle_en = !(phase >= 8 && phase < 20);
      paint_random_rect(phase);
    end
    settle();

    if (tracker.mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
